// File: rtl/gsc_pkg.sv
`default_nettype none

package gsc_pkg;

    // Field widths of the input and result words.
    localparam int DATA_W = 16;
    localparam int SIZE_W = 12;

    // Default depth of the averaging window.
    localparam int WINDOW_DEF = 5;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_LR_START  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LR_END    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UD_START  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UD_END    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCR_WIDTH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCR_HEIGHT = 3'd5;

    // Register values after reset (Q8.8 for the ranges, pixels for the sizes).
    localparam logic signed [DATA_W-1:0] RST_LR_START = 16'sd11520;
    localparam logic signed [DATA_W-1:0] RST_LR_END   = 16'sd7680;
    localparam logic signed [DATA_W-1:0] RST_UD_START = 16'sd5120;
    localparam logic signed [DATA_W-1:0] RST_UD_END   = 16'sd8960;
    localparam logic [SIZE_W-1:0] RST_SCR_WIDTH  = 12'd1920;
    localparam logic [SIZE_W-1:0] RST_SCR_HEIGHT = 12'd1080;

    typedef struct packed {
        logic signed [DATA_W-1:0] gaze_horizontal;
        logic signed [DATA_W-1:0] gaze_vertical;
    } t_in_word;

    typedef struct packed {
        logic [SIZE_W-1:0] cursor_x;
        logic [SIZE_W-1:0] cursor_y;
    } t_out_word;

    // Control from the merge stage into a lane.
    typedef struct packed {
        logic start;
        logic ack;
    } t_lane_ctl;

    // Status from a lane back to the merge stage.
    typedef struct packed {
        logic              idle;
        logic              done;
        logic [SIZE_W-1:0] cursor;
    } t_lane_stat;

    typedef enum logic [2:0] {
        LS_IDLE,
        LS_MUL1,
        LS_MUL2,
        LS_DIV,
        LS_DONE
    } t_lane_state;

    // Width of the fill counter, which must hold WINDOW itself.
    function automatic int cnt_w(input int w);
        return $clog2(w + 1);
    endfunction

    // Width of the write slot index.
    function automatic int slot_w(input int w);
        return (w > 1) ? $clog2(w) : 1;
    endfunction

    // Width of a window sum.
    function automatic int sum_w(input int w);
        return DATA_W + $clog2(w);
    endfunction

endpackage

`default_nettype wire

// File: rtl/gsc_window.sv
`default_nettype none

module gsc_window
    import gsc_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_push,
    input  wire logic [slot_w(WINDOW)-1:0]       i_slot,
    input  wire logic                            i_full,
    input  wire logic signed [DATA_W-1:0]        i_sample,
    output logic signed [sum_w(WINDOW)-1:0]      o_sum
);

    localparam int SUM_W = sum_w(WINDOW);

    logic signed [DATA_W-1:0] r_win [WINDOW];
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [SUM_W-1:0]  n_sum;
    logic signed [SUM_W-1:0]  old_ext;

    // The oldest sample leaves the sum only once the window is full.
    assign old_ext = i_full ? SUM_W'(r_win[i_slot]) : '0;
    assign n_sum   = r_sum - old_ext + SUM_W'(i_sample);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_win[i_slot] <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_push) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

`default_nettype wire

// File: rtl/gsc_div.sv
`default_nettype none

module gsc_div
    import gsc_pkg::*;
#(
    parameter int NUM_W = 32,
    parameter int DEN_W = 20
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic                  o_busy,
    output logic [NUM_W-1:0]      o_quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_q;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_sub;
    logic             fits;

    // Restoring division, one quotient bit per cycle, numerator shifted out MSB first.
    assign rem_sh  = {r_rem, r_q[NUM_W-1]};
    assign fits    = rem_sh >= {1'b0, r_den};
    assign rem_sub = rem_sh - {1'b0, r_den};
    assign o_busy  = (r_cnt != '0);
    assign o_quot  = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(NUM_W);
        end else if (o_busy) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (o_busy) begin
            r_rem <= fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            r_q   <= {r_q[NUM_W-2:0], fits};
        end
    end

endmodule

`default_nettype wire

// File: rtl/gsc_lane.sv
`default_nettype none

module gsc_lane
    import gsc_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire t_lane_ctl                   i_ctl,
    output t_lane_stat                       o_stat,
    input  wire logic signed [DATA_W-1:0]    i_sample,
    input  wire logic [slot_w(WINDOW)-1:0]   i_slot,
    input  wire logic                        i_full,
    input  wire logic [cnt_w(WINDOW)-1:0]    i_fill,
    input  wire logic signed [DATA_W-1:0]    i_range_start,
    input  wire logic signed [DATA_W-1:0]    i_range_end,
    input  wire logic [SIZE_W-1:0]           i_size
);

    localparam int CNT_W  = cnt_w(WINDOW);
    localparam int SUM_W  = sum_w(WINDOW);
    localparam int DIFF_W = 18 + CNT_W;
    localparam int DEN_W  = 18 + CNT_W;
    localparam int NUM_W  = DIFF_W - 1 + SIZE_W;

    t_lane_state r_state;
    t_lane_state n_state;

    logic signed [SUM_W-1:0]        sum;
    logic signed [CNT_W:0]          n_s;
    logic signed [CNT_W+DATA_W:0]   n_start;
    logic signed [DATA_W:0]         span;
    logic signed [DEN_W-1:0]        den_full;
    logic signed [DIFF_W-1:0]       diff;
    logic signed [DIFF_W-1:0]       r_diff;
    logic signed [DEN_W-1:0]        r_den;
    logic                           neg;
    logic signed [DIFF_W-1:0]       diff_abs;
    logic signed [DEN_W-1:0]        den_abs;
    logic [NUM_W-1:0]               num;
    logic                           zero;
    logic                           r_zero;
    logic                           div_start;
    logic                           div_busy;
    logic [NUM_W-1:0]               quot;
    logic [SIZE_W-1:0]              cursor;
    logic [SIZE_W-1:0]              r_cursor;

    gsc_window #(
        .WINDOW (WINDOW)
    ) u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (i_ctl.start),
        .i_slot   (i_slot),
        .i_full   (i_full),
        .i_sample (i_sample),
        .o_sum    (sum)
    );

    // First step: numerator before scaling, and the denominator.
    assign n_s      = {1'b0, i_fill};
    assign n_start  = (CNT_W+DATA_W+1)'(n_s) * (CNT_W+DATA_W+1)'(i_range_start);
    assign span     = (DATA_W+1)'(i_range_end) - (DATA_W+1)'(i_range_start);
    assign den_full = DEN_W'(n_s) * DEN_W'(span);
    assign diff     = DIFF_W'(sum) - DIFF_W'(n_start);

    // Second step: fold the denominator sign into the numerator, then scale.
    assign neg      = r_den[DEN_W-1];
    assign diff_abs = neg ? -r_diff : r_diff;
    assign den_abs  = neg ? -r_den : r_den;
    assign zero     = (r_den == '0) || diff_abs[DIFF_W-1] || (diff_abs == '0)
                      || (i_size == '0);
    assign num      = NUM_W'(diff_abs[DIFF_W-2:0]) * NUM_W'(i_size);

    gsc_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W - 1)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num),
        .i_den   (den_abs[DEN_W-2:0]),
        .o_busy  (div_busy),
        .o_quot  (quot)
    );

    // Clamp the quotient to the display size.
    always_comb begin
        if (r_zero) begin
            cursor = '0;
        end else if (quot > NUM_W'(i_size)) begin
            cursor = i_size;
        end else begin
            cursor = quot[SIZE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= LS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        o_stat    = '{idle: 1'b0, done: 1'b0, cursor: r_cursor};
        unique case (r_state)
            LS_IDLE: begin
                o_stat.idle = 1'b1;
                if (i_ctl.start) begin
                    n_state = LS_MUL1;
                end
            end
            LS_MUL1: begin
                n_state = LS_MUL2;
            end
            LS_MUL2: begin
                div_start = 1'b1;
                n_state   = LS_DIV;
            end
            LS_DIV: begin
                if (!div_busy) begin
                    n_state = LS_DONE;
                end
            end
            LS_DONE: begin
                o_stat.done = 1'b1;
                if (i_ctl.ack) begin
                    n_state = LS_IDLE;
                end
            end
            default: begin
                n_state = LS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == LS_MUL1) begin
            r_diff <= diff;
            r_den  <= den_full;
        end
        if (r_state == LS_MUL2) begin
            r_zero <= zero;
        end
        if ((r_state == LS_DIV) && !div_busy) begin
            r_cursor <= cursor;
        end
    end

endmodule

`default_nettype wire

// File: rtl/gaze_smoother_to_cursor_unit.sv
`default_nettype none

// Gaze smoother to cursor position.
// Input channel (i_in_valid / o_in_ready / i_in_word): one word carries a
// horizontal and a vertical gaze sample in signed Q8.8. The block keeps the
// last WINDOW samples of each axis, averages over the samples held so far,
// maps the average linearly from the configured gaze range onto 0..screen
// size, truncates toward zero and clamps to 0..size. An empty range gives 0.
// Output channel (o_out_valid / i_out_ready / o_out_word): one cursor word
// per input word, in order. Configuration channel (i_cfg_valid / o_cfg_ready
// / i_cfg_index / i_cfg_data) is always ready; indexes beyond the register
// list are ignored. Write it only while no word is in flight.
// Two identical lanes, one per axis, work side by side; each ends in a
// restoring divider that yields one quotient bit per cycle. That divider sets
// the rate: no new input word is taken while one is in the lanes, and the
// next one can be taken in the same cycle that the last one's result word
// becomes valid, while the receiver keeps up. The output register holds a
// finished word while the receiver stalls; the lanes then wait with their
// next result and take no new input until it moves on.
// Reset clears the sums, the fill count and the write slot, and loads the registers
// with their default ranges and a 1920 by 1080 screen.

module gaze_smoother_to_cursor_unit
    import gsc_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in_word              i_in_word,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_word                  o_out_word,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [DATA_W-1:0]     i_cfg_data
);

    localparam int CNT_W  = cnt_w(WINDOW);
    localparam int SLOT_W = slot_w(WINDOW);

    // Configuration registers.
    logic signed [DATA_W-1:0] r_lr_start;
    logic signed [DATA_W-1:0] r_lr_end;
    logic signed [DATA_W-1:0] r_ud_start;
    logic signed [DATA_W-1:0] r_ud_end;
    logic [SIZE_W-1:0]        r_scr_width;
    logic [SIZE_W-1:0]        r_scr_height;

    // Window bookkeeping shared by both lanes.
    logic [CNT_W-1:0]  r_fill;
    logic [SLOT_W-1:0] r_slot;
    logic              full;

    logic       r_out_valid;
    t_out_word  r_out_word;

    t_lane_ctl  lane_ctl;
    t_lane_stat stat_x;
    t_lane_stat stat_y;
    logic       in_take;
    logic       merge;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr_start   <= RST_LR_START;
            r_lr_end     <= RST_LR_END;
            r_ud_start   <= RST_UD_START;
            r_ud_end     <= RST_UD_END;
            r_scr_width  <= RST_SCR_WIDTH;
            r_scr_height <= RST_SCR_HEIGHT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LR_START:   r_lr_start   <= i_cfg_data;
                CFG_LR_END:     r_lr_end     <= i_cfg_data;
                CFG_UD_START:   r_ud_start   <= i_cfg_data;
                CFG_UD_END:     r_ud_end     <= i_cfg_data;
                CFG_SCR_WIDTH:  r_scr_width  <= i_cfg_data[SIZE_W-1:0];
                CFG_SCR_HEIGHT: r_scr_height <= i_cfg_data[SIZE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // A new word enters only when both lanes are idle. The lanes run in
    // lockstep, so they report done in the same cycle; the merge stage moves
    // both cursors into the output register when it is free or draining.
    assign o_in_ready = stat_x.idle && stat_y.idle;
    assign in_take    = i_in_valid && o_in_ready;
    assign merge      = stat_x.done && stat_y.done && (!r_out_valid || i_out_ready);
    assign lane_ctl   = '{start: in_take, ack: merge};
    assign full       = (r_fill == CNT_W'(WINDOW));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_slot <= '0;
        end else if (in_take) begin
            if (!full) begin
                r_fill <= r_fill + 1'b1;
            end
            r_slot <= (r_slot == SLOT_W'(WINDOW - 1)) ? '0 : r_slot + 1'b1;
        end
    end

    gsc_lane #(
        .WINDOW (WINDOW)
    ) u_lane_x (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (lane_ctl),
        .o_stat        (stat_x),
        .i_sample      (i_in_word.gaze_horizontal),
        .i_slot        (r_slot),
        .i_full        (full),
        .i_fill        (r_fill),
        .i_range_start (r_lr_start),
        .i_range_end   (r_lr_end),
        .i_size        (r_scr_width)
    );

    gsc_lane #(
        .WINDOW (WINDOW)
    ) u_lane_y (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (lane_ctl),
        .o_stat        (stat_y),
        .i_sample      (i_in_word.gaze_vertical),
        .i_slot        (r_slot),
        .i_full        (full),
        .i_fill        (r_fill),
        .i_range_start (r_ud_start),
        .i_range_end   (r_ud_end),
        .i_size        (r_scr_height)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (merge) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (merge) begin
            r_out_word <= '{cursor_x: stat_x.cursor, cursor_y: stat_y.cursor};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

`default_nettype wire

// File: tb/gaze_smoother_to_cursor_unit_tb.sv
`default_nettype none

// Self-checking bench for the gaze smoother. A clocked driver offers sample
// words from a queue, a clocked monitor takes cursor words and compares them
// with the words predicted when each sample word was accepted, and a watchdog
// ends the run if the handshakes stop moving. Range and screen registers are
// only rewritten while nothing is in flight.
module gaze_smoother_to_cursor_unit_tb;
    import gsc_pkg::*;

    // The window depth is the block's default.
    localparam int WIN = WINDOW_DEF;
    // Cycles to let pass once the last cursor word has arrived.
    localparam int SETTLE_CYCLES = 50;
    // Receiver hold-off long enough to fill both lanes and the output
    // register many times over, so the input side must stall.
    localparam int LONG_HOLD = 400;
    // Cycles without any handshake before the run is declared hung. The long
    // hold-off above is the longest legitimate quiet stretch.
    localparam int QUIET_LIMIT = 4000;
    localparam int RANDOM_SEGMENTS = 4;
    localparam int SEGMENT_WORDS = 71;

    // Register indexes beyond the register list; writes to them are ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    // Clock and reset.
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #1 i_clk = ~i_clk;

    // Block inputs, all known from time zero.
    logic in_valid = 1'b0;
    t_in_word in_word = '0;
    logic out_ready = 1'b0;
    logic cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0] cfg_data = '0;

    // Block outputs.
    logic o_in_ready;
    logic o_out_valid;
    t_out_word o_out_word;
    logic o_cfg_ready;

    gaze_smoother_to_cursor_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // Sample words waiting to be offered, and cursor words still owed by the
    // block, oldest first.
    t_in_word pending_words[$];
    t_out_word cursor_expect[$];

    // Idle percentages of the two sides, set per phase by the stimulus.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // Long receiver stall: armed once by the stimulus, carried out by the
    // monitor, which counts the cycles itself.
    logic stall_armed = 1'b0;
    logic stall_taken = 1'b0;
    int hold_left = 0;

    int mismatch_count = 0;
    int quiet_cycles = 0;
    t_out_word cursor_want;

    // Our own copy of the registers, loaded with their reset values.
    logic signed [DATA_W-1:0] lr_start = RST_LR_START;
    logic signed [DATA_W-1:0] lr_stop = RST_LR_END;
    logic signed [DATA_W-1:0] ud_start = RST_UD_START;
    logic signed [DATA_W-1:0] ud_stop = RST_UD_END;
    logic [SIZE_W-1:0] scr_w = RST_SCR_WIDTH;
    logic [SIZE_W-1:0] scr_h = RST_SCR_HEIGHT;

    // Our own copy of the averaging window; reset clears all of it.
    longint h_hist[WIN];
    longint v_hist[WIN];
    int held = 0;
    int next_slot = 0;
    longint h_total = 0;
    longint v_total = 0;

    initial begin
        for (int i = 0; i < WIN; i++) begin
            h_hist[i] = 0;
            v_hist[i] = 0;
        end
    end

    // Maps the sum of n samples onto 0..size exactly:
    // trunc((sum - n*start) * size / (n * (stop - start))), clamped to 0..size.
    // An empty range gives 0, and so does any negative or fractional value
    // below zero.
    function automatic logic [SIZE_W-1:0] map_axis(input longint total,
                                                   input longint n,
                                                   input longint start,
                                                   input longint stop,
                                                   input longint size);
        longint num;
        longint den;
        longint q;
        num = (total - n * start) * size;
        den = n * (stop - start);
        if (den == 0)
            return '0;
        if (den < 0) begin
            den = -den;
            num = -num;
        end
        if (num <= 0)
            return '0;
        q = num / den;
        if (q > size)
            q = size;
        return q[SIZE_W-1:0];
    endfunction

    // Pushes one sample pair into the window, oldest out once it is full, and
    // queues the cursor word the block must produce for it.
    task automatic slide_and_map(input t_in_word w);
        t_out_word c;
        if (held >= WIN) begin
            h_total -= h_hist[next_slot];
            v_total -= v_hist[next_slot];
        end else begin
            held++;
        end
        h_hist[next_slot] = longint'(w.gaze_horizontal);
        v_hist[next_slot] = longint'(w.gaze_vertical);
        h_total += longint'(w.gaze_horizontal);
        v_total += longint'(w.gaze_vertical);
        next_slot = (next_slot + 1) % WIN;
        c.cursor_x = map_axis(h_total, held, longint'(lr_start), longint'(lr_stop),
                              longint'(scr_w));
        c.cursor_y = map_axis(v_total, held, longint'(ud_start), longint'(ud_stop),
                              longint'(scr_h));
        cursor_expect = {cursor_expect, c};
    endtask

    // Driver. A word stays on the bus, unchanged, until it is accepted; only
    // then does the next one get a chance, subject to the random idle rate.
    // The queue front is popped only on acceptance, so what was driven is
    // always what gets predicted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                slide_and_map(in_word);
                void'(pending_words.pop_front());
            end
            if (in_valid && !o_in_ready) begin
                in_valid <= 1'b1;
            end else if (pending_words.size() != 0 &&
                         $urandom_range(99) >= send_idle_pct) begin
                in_valid <= 1'b1;
                in_word <= pending_words[0];
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor. Every accepted cursor word is checked against the oldest
    // prediction, field by field. Ready is dropped at random, and once for a
    // long hold-off when the stimulus asks for it.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            hold_left <= 0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (cursor_expect.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("unexpected cursor word x=%0d y=%0d",
                                 o_out_word.cursor_x, o_out_word.cursor_y);
                    mismatch_count++;
                end else begin
                    cursor_want = cursor_expect.pop_front();
                    if (o_out_word.cursor_x !== cursor_want.cursor_x ||
                        o_out_word.cursor_y !== cursor_want.cursor_y) begin
                        if (mismatch_count < 10)
                            $display("cursor mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
                                     cursor_want.cursor_x, cursor_want.cursor_y,
                                     o_out_word.cursor_x, o_out_word.cursor_y);
                        mismatch_count++;
                    end
                end
            end
            if (stall_armed && !stall_taken) begin
                stall_taken <= 1'b1;
                hold_left <= LONG_HOLD;
                out_ready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: any handshake on any channel counts as progress.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready) ||
                (cfg_valid && o_cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb: failure");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Writes one register and mirrors it in our copy once it is accepted.
    // Called at a rising edge; the caller drops valid after its last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_LR_START:   lr_start = data;
            CFG_LR_END:     lr_stop = data;
            CFG_UD_START:   ud_start = data;
            CFG_UD_END:     ud_stop = data;
            CFG_SCR_WIDTH:  scr_w = data[SIZE_W-1:0];
            CFG_SCR_HEIGHT: scr_h = data[SIZE_W-1:0];
            default: ;
        endcase
    endtask

    // Waits until every queued word has gone in and every cursor word has come
    // out, then lets the block settle before registers may change.
    task automatic wait_drained();
        while (pending_words.size() != 0 || cursor_expect.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_pair(input logic [DATA_W-1:0] h, input logic [DATA_W-1:0] v);
        t_in_word w;
        w.gaze_horizontal = h;
        w.gaze_vertical = v;
        pending_words = {pending_words, w};
    endtask

    // A gaze value mostly inside the configured range, with a margin on both
    // sides so that clamping at 0 and at the size happens too. One in ten is
    // fully random so every bit of the field toggles.
    function automatic logic [DATA_W-1:0] pick_gaze(input logic signed [DATA_W-1:0] a,
                                                    input logic signed [DATA_W-1:0] b);
        int lo;
        int hi;
        int margin;
        int r;
        if ($urandom_range(9) == 0)
            return DATA_W'($urandom);
        lo = (a < b) ? int'(a) : int'(b);
        hi = (a < b) ? int'(b) : int'(a);
        margin = (hi - lo) / 4 + 64;
        r = lo - margin + int'($urandom_range(hi - lo + 2 * margin));
        if (r < -32768)
            r = -32768;
        if (r > 32767)
            r = 32767;
        return DATA_W'(r);
    endfunction

    // A range end: usually moderate, sometimes one of the extremes.
    function automatic logic [DATA_W-1:0] pick_range_end();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return DATA_W'($urandom);
            default: return DATA_W'(int'($urandom_range(24000)) - 12000);
        endcase
    endfunction

    // A screen size with random bits above the 12 that count: usually
    // random, sometimes the largest, the smallest, or zero.
    function automatic logic [DATA_W-1:0] pick_size();
        logic [3:0] junk;
        junk = 4'($urandom);
        case ($urandom_range(7))
            0: return {junk, 12'd4095};
            1: return {junk, 12'd1};
            2: return {junk, 12'd0};
            default: return {junk, 12'($urandom_range(4095, 1))};
        endcase
    endfunction

    // Stimulus.
    initial begin
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, default registers: the window fills up from one sample,
        // so the first results average fewer than WINDOW samples. The
        // horizontal range runs downward by default.
        queue_pair(16'd0, 16'd0);
        queue_pair(16'h7fff, 16'h7fff);
        queue_pair(16'h8000, 16'h8000);
        queue_pair(16'd9600, 16'd7040);
        queue_pair(16'd11520, 16'd5120);
        queue_pair(16'd7680, 16'd8960);
        wait_drained();

        // Widest ranges, one upward and one downward, largest screen, plus
        // writes to indexes past the register list, which must change nothing.
        write_reg(CFG_LR_START, 16'h8000);
        write_reg(CFG_LR_END, 16'h7fff);
        write_reg(CFG_UD_START, 16'h7fff);
        write_reg(CFG_UD_END, 16'h8000);
        write_reg(CFG_SCR_WIDTH, 16'hffff);
        write_reg(CFG_SCR_HEIGHT, 16'h0fff);
        write_reg(CFG_SPARE_LO, 16'h1234);
        write_reg(CFG_SPARE_HI, 16'hffff);
        cfg_valid <= 1'b0;
        queue_pair(16'h7fff, 16'h8000);
        queue_pair(16'h8000, 16'h7fff);
        queue_pair(16'd0, 16'd0);
        queue_pair(16'hffff, 16'h0001);
        wait_drained();

        // Empty horizontal range and a zero height, then an empty vertical
        // range and a zero width. Small values around a range start that is
        // zero reach the fractions just below zero.
        write_reg(CFG_LR_START, 16'd100);
        write_reg(CFG_LR_END, 16'd100);
        write_reg(CFG_UD_START, 16'd0);
        write_reg(CFG_UD_END, 16'd1000);
        write_reg(CFG_SCR_WIDTH, 16'd1);
        write_reg(CFG_SCR_HEIGHT, 16'd0);
        cfg_valid <= 1'b0;
        queue_pair(16'd100, 16'd500);
        queue_pair(16'hffff, 16'hffff);
        wait_drained();
        write_reg(CFG_LR_START, 16'd0);
        write_reg(CFG_LR_END, 16'd256);
        write_reg(CFG_UD_START, 16'd256);
        write_reg(CFG_UD_END, 16'd256);
        write_reg(CFG_SCR_WIDTH, 16'd0);
        write_reg(CFG_SCR_HEIGHT, 16'd1);
        cfg_valid <= 1'b0;
        queue_pair(16'd300, 16'd256);
        queue_pair(16'hfffe, 16'd0);
        wait_drained();
        write_reg(CFG_SCR_WIDTH, 16'd4095);
        cfg_valid <= 1'b0;
        queue_pair(16'hffff, 16'd1);
        queue_pair(16'd1, 16'hfffe);
        wait_drained();

        // Random part in three idle modes: sender 23 / receiver 46, then the
        // other way round, then no idling at all. Each mode runs through
        // several register settings with fresh ranges and sizes.
        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct = (mode == 0) ? 23 : (mode == 1) ? 46 : 0;
            recv_idle_pct = (mode == 0) ? 46 : (mode == 1) ? 23 : 0;
            for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
                a = pick_range_end();
                b = ($urandom_range(9) == 0) ? a : pick_range_end();
                write_reg(CFG_LR_START, a);
                write_reg(CFG_LR_END, b);
                a = pick_range_end();
                b = ($urandom_range(9) == 0) ? a : pick_range_end();
                write_reg(CFG_UD_START, a);
                write_reg(CFG_UD_END, b);
                write_reg(CFG_SCR_WIDTH, pick_size());
                write_reg(CFG_SCR_HEIGHT, pick_size());
                if ($urandom_range(3) == 0)
                    write_reg($urandom_range(1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                              DATA_W'($urandom));
                cfg_valid <= 1'b0;
                for (int k = 0; k < SEGMENT_WORDS; k++)
                    queue_pair(pick_gaze(lr_start, lr_stop), pick_gaze(ud_start, ud_stop));
                // Once, with a full queue, the receiver holds off for a long
                // stretch while the driver keeps offering words.
                if (mode == 0 && seg == 1)
                    stall_armed = 1'b1;
                wait_drained();
            end
        end

        if (mismatch_count == 0 && cursor_expect.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
